[hdl/s2l_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s2l_pkg: shared types, constants and table builders
// sRGB to CIE L*a*b* (D65): fixed-point formats, matrix coefficients and
// the elaboration-time builders for the linearizing and Lab f tables.
// ----------------------------------------------------------------------------
package s2l_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam int LIN_W    = 17;   // Q16 linear value, 1.0 included
  localparam int COEF_W   = 20;   // Q20 matrix coefficient
  localparam int PROD_W   = LIN_W + COEF_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int RATIO_W  = 21;   // Q20 ratio after clamp
  localparam int K_W      = 11;
  localparam int Q_W      = 10;
  localparam int F_W      = 21;   // Q20 f value
  localparam int LIN_SIZE = 256;
  localparam int F_SIZE   = 1026;

  localparam logic [RATIO_W-1:0] RATIO_MAX = 21'd1049599;

  localparam logic [63:0] LIN_DIV  = 64'd269025;
  localparam logic [63:0] LOW_DIV  = 64'd329460;
  localparam logic [63:0] F_DIV    = 64'd3132;
  localparam logic [63:0] X_DIV    = 64'd95047;
  localparam logic [63:0] Y_DIV    = 64'd10000;
  localparam logic [63:0] Z_DIV    = 64'd108883;

  typedef struct packed {
    logic [K_W-1:0] k;
    logic [Q_W-1:0] q;
  } f_idx_t;

  typedef logic [LIN_W-1:0] lin_tab_t [LIN_SIZE];
  typedef logic [F_W-1:0]   f_tab_t   [F_SIZE];

  function automatic logic [63:0] mat_num(input int row, input int col);
    logic [63:0] n;
    n = 64'd0;
    case (row * 3 + col)
      0: n = 64'd4124;
      1: n = 64'd3576;
      2: n = 64'd1805;
      3: n = 64'd2126;
      4: n = 64'd7152;
      5: n = 64'd722;
      6: n = 64'd193;
      7: n = 64'd1192;
      8: n = 64'd9505;
      default: n = 64'd0;
    endcase
    return n;
  endfunction

  // XYZ matrix with the D65 white point folded in, Q20, rounded
  function automatic logic [COEF_W-1:0] coef_q20(input int row, input int col);
    logic [63:0] c;
    logic [63:0] r;
    c = mat_num(row, col);
    case (row)
      0:       r = (c * 64'd10 * 64'd1048576 + X_DIV / 64'd2) / X_DIV;
      1:       r = (c * 64'd1048576 + Y_DIV / 64'd2) / Y_DIV;
      default: r = (c * 64'd10 * 64'd1048576 + Z_DIV / 64'd2) / Z_DIV;
    endcase
    return r[COEF_W-1:0];
  endfunction

  function automatic logic [63:0] pow5_q30(input logic [63:0] r);
    logic [63:0] p;
    p = (r * r) >> 30;
    p = (p * r) >> 30;
    p = (p * r) >> 30;
    return (p * r) >> 30;
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t    tab;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] r;
    for (int v = 0; v < LIN_SIZE; v++) begin
      if (v <= 10) begin
        r = (64'(v) * 64'd6553600 + LOW_DIV / 64'd2) / LOW_DIV;
      end else begin
        t  = ((64'(v) * 64'd1000 + 64'd14025) << 30) / LIN_DIV;
        u  = (t * t) >> 30;
        lo = 64'd0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (pow5_q30(mid) <= u) lo = mid;
          else hi = mid - 64'd1;
        end
        r = (((u * lo) >> 30) + 64'd8192) >> 14;
      end
      tab[v] = r[LIN_W-1:0];
    end
    return tab;
  endfunction

  // one Lab f entry at x = k/1024: linear segment, else integer cube root
  function automatic logic [F_W-1:0] f_entry(input int k);
    logic [63:0] n;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] r;
    if (k <= 9) begin
      r = (64'd24389 * 64'(k) * 64'd1024 + (64'd432 << 20) + F_DIV / 64'd2) / F_DIV;
    end else begin
      n  = 64'(k) << 50;
      lo = 64'd0;
      hi = (64'd1 << 21) - 64'd1;
      while (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (mid * mid * mid <= n) lo = mid;
        else hi = mid - 64'd1;
      end
      r = lo;
    end
    return r[F_W-1:0];
  endfunction

  function automatic f_tab_t build_f_tab();
    f_tab_t tab;
    for (int k = 0; k < F_SIZE; k += 2) begin
      tab[k]     = f_entry(k);
      tab[k + 1] = f_entry(k + 1);
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

[hdl/s2l_matrix.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s2l_matrix: linearize and transform to normalized XYZ
// Three stages: sRGB curve lookup, nine products, row sums with rounding,
// clamp and split into f table index and interpolation fraction.
// ----------------------------------------------------------------------------
module s2l_matrix (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                in_red,
  input  wire logic [7:0]                in_green,
  input  wire logic [7:0]                in_blue,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output s2l_pkg::f_idx_t [2:0]          out_idx
);

  localparam int LW = s2l_pkg::LIN_W;
  localparam int PW = s2l_pkg::PROD_W;
  localparam int SW = s2l_pkg::SUM_W;
  localparam int RW = s2l_pkg::RATIO_W;

  localparam s2l_pkg::lin_tab_t LIN_TAB = s2l_pkg::build_lin_tab();

  localparam logic [s2l_pkg::COEF_W-1:0] COEF [3][3] = '{
    '{s2l_pkg::coef_q20(0, 0), s2l_pkg::coef_q20(0, 1), s2l_pkg::coef_q20(0, 2)},
    '{s2l_pkg::coef_q20(1, 0), s2l_pkg::coef_q20(1, 1), s2l_pkg::coef_q20(1, 2)},
    '{s2l_pkg::coef_q20(2, 0), s2l_pkg::coef_q20(2, 1), s2l_pkg::coef_q20(2, 2)}
  };

  logic          va_r, vb_r, vc_r;
  logic          rdy_a, rdy_b, rdy_c;
  logic [LW-1:0] lin_r  [3];
  logic [PW-1:0] prod_r [3][3];
  s2l_pkg::f_idx_t [2:0] idx_r;
  s2l_pkg::f_idx_t [2:0] idx_nxt;

  assign rdy_c    = !vc_r || out_ready;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      lin_r[0] <= LIN_TAB[in_red];
      lin_r[1] <= LIN_TAB[in_green];
      lin_r[2] <= LIN_TAB[in_blue];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk) begin
        if (rdy_b) prod_r[i][j] <= PW'(lin_r[j]) * PW'(COEF[i][j]);
      end
    end
  end

  always_comb begin
    logic [SW-1:0]   sum;
    logic [SW-17:0]  ratio_full;
    logic [RW-1:0]   ratio;
    for (int i = 0; i < 3; i++) begin
      sum = SW'(prod_r[i][0]) + SW'(prod_r[i][1]) + SW'(prod_r[i][2]) + SW'(32768);
      ratio_full = sum[SW-1:16];
      if (ratio_full > (SW-16)'(s2l_pkg::RATIO_MAX)) ratio = s2l_pkg::RATIO_MAX;
      else ratio = ratio_full[RW-1:0];
      idx_nxt[i].k = ratio[RW-1:s2l_pkg::Q_W];
      idx_nxt[i].q = ratio[s2l_pkg::Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) idx_r <= idx_nxt;
  end

  assign out_valid = vc_r;
  assign out_idx   = idx_r;

endmodule
`default_nettype wire

[hdl/s2l_f_rom.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s2l_f_rom: Lab f table
// 1026-entry Q20 ROM with two registered read ports, neighbor entries for
// linear interpolation.
// ----------------------------------------------------------------------------
module s2l_f_rom (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [s2l_pkg::K_W-1:0]     addr_lo,
  input  wire logic [s2l_pkg::K_W-1:0]     addr_hi,
  output logic      [s2l_pkg::F_W-1:0]     data_lo,
  output logic      [s2l_pkg::F_W-1:0]     data_hi
);

  localparam s2l_pkg::f_tab_t F_TAB = s2l_pkg::build_f_tab();

  logic [s2l_pkg::F_W-1:0] lo_r, hi_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r <= F_TAB[addr_lo];
      hi_r <= F_TAB[addr_hi];
    end
  end

  assign data_lo = lo_r;
  assign data_hi = hi_r;

endmodule
`default_nettype wire

[hdl/s2l_lab_f.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s2l_lab_f: Lab f function for X, Y and Z
// Two stages: table read at k and k+1, then linear interpolation by q.
// ----------------------------------------------------------------------------
module s2l_lab_f (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire s2l_pkg::f_idx_t [2:0]         in_idx,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0][s2l_pkg::F_W-1:0]       out_f
);

  localparam int FW = s2l_pkg::F_W;
  localparam int QW = s2l_pkg::Q_W;
  localparam int MW = FW + QW + 1;

  logic          vd_r, ve_r;
  logic          rdy_d, rdy_e;
  logic [QW-1:0] q_r [3];
  logic [FW-1:0] lo   [3];
  logic [FW-1:0] hi   [3];
  logic [2:0][FW-1:0] f_r;
  logic [2:0][FW-1:0] f_nxt;

  assign rdy_e    = !ve_r || out_ready;
  assign rdy_d    = !vd_r || rdy_e;
  assign in_ready = rdy_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      if (rdy_d) vd_r <= in_valid;
      if (rdy_e) ve_r <= vd_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_ch
    s2l_f_rom u_rom (
      .clk     (clk),
      .en      (rdy_d),
      .addr_lo (in_idx[i].k),
      .addr_hi (in_idx[i].k + s2l_pkg::K_W'(1)),
      .data_lo (lo[i]),
      .data_hi (hi[i])
    );

    always_ff @(posedge clk) begin
      if (rdy_d) q_r[i] <= in_idx[i].q;
    end
  end

  always_comb begin
    logic [FW-1:0] diff;
    logic [MW-1:0] prod;
    for (int i = 0; i < 3; i++) begin
      diff     = hi[i] - lo[i];
      prod     = MW'(diff) * MW'(q_r[i]) + MW'(512);
      f_nxt[i] = lo[i] + prod[FW+QW-1:QW];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e) f_r <= f_nxt;
  end

  assign out_valid = ve_r;
  assign out_f     = f_r;

endmodule
`default_nettype wire

[hdl/s2l_lab_out.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s2l_lab_out: L*, a*, b* from f values
// Two stages: scaled differences in Q20, then rounding to the output
// fraction width and saturation into the output register.
// ----------------------------------------------------------------------------
module s2l_lab_out #(
  parameter int FRAC_BITS = s2l_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [2:0][s2l_pkg::F_W-1:0]  in_f,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic        [14:0]                 out_lightness,
  output logic signed [15:0]                 out_green_red,
  output logic signed [15:0]                 out_blue_yellow
);

  localparam int P_W    = 33;
  localparam int SH     = 20 - FRAC_BITS;
  localparam int LMAX_I = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);

  localparam logic signed [P_W-1:0] C116   = 116;
  localparam logic signed [P_W-1:0] C500   = 500;
  localparam logic signed [P_W-1:0] C200   = 200;
  localparam logic signed [P_W-1:0] OFS16  = 16 << 20;
  localparam logic signed [P_W-1:0] HALF   = P_W'(1) << (SH - 1);
  localparam logic signed [P_W-1:0] LMAX   = LMAX_I;
  localparam logic signed [P_W-1:0] CH_MIN = -32768;
  localparam logic signed [P_W-1:0] CH_MAX = 32767;

  logic vf_r, vg_r;
  logic rdy_f, rdy_g;

  logic signed [P_W-1:0] fx, fy, fz;
  logic signed [P_W-1:0] l_pre_r, a_pre_r, b_pre_r;
  logic signed [P_W-1:0] lr, ar, br;

  logic        [14:0] l_r, l_nxt;
  logic signed [15:0] a_r, a_nxt, b_r, b_nxt;

  assign rdy_g    = !vg_r || out_ready;
  assign rdy_f    = !vf_r || rdy_g;
  assign in_ready = rdy_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
      vg_r <= 1'b0;
    end else begin
      if (rdy_f) vf_r <= in_valid;
      if (rdy_g) vg_r <= vf_r;
    end
  end

  assign fx = signed'(P_W'(in_f[0]));
  assign fy = signed'(P_W'(in_f[1]));
  assign fz = signed'(P_W'(in_f[2]));

  always_ff @(posedge clk) begin
    if (rdy_f) begin
      l_pre_r <= fy * C116 - OFS16;
      a_pre_r <= (fx - fy) * C500;
      b_pre_r <= (fy - fz) * C200;
    end
  end

  // round to nearest, ties up: add half then floor
  assign lr = (l_pre_r + HALF) >>> SH;
  assign ar = (a_pre_r + HALF) >>> SH;
  assign br = (b_pre_r + HALF) >>> SH;

  always_comb begin
    if (lr < 0) l_nxt = '0;
    else if (lr > LMAX) l_nxt = LMAX[14:0];
    else l_nxt = lr[14:0];

    if (ar < CH_MIN) a_nxt = CH_MIN[15:0];
    else if (ar > CH_MAX) a_nxt = CH_MAX[15:0];
    else a_nxt = ar[15:0];

    if (br < CH_MIN) b_nxt = CH_MIN[15:0];
    else if (br > CH_MAX) b_nxt = CH_MAX[15:0];
    else b_nxt = br[15:0];
  end

  always_ff @(posedge clk) begin
    if (rdy_g) begin
      l_r <= l_nxt;
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  assign out_valid       = vg_r;
  assign out_lightness   = l_r;
  assign out_green_red   = a_r;
  assign out_blue_yellow = b_r;

endmodule
`default_nettype wire

[hdl/srgb_to_cielab_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srgb_to_cielab_unit: sRGB to CIE L*a*b* converter, D65 white point
// Takes one 8-bit sRGB pixel per word and returns L*, a* and b* with
// FRAC_BITS fraction bits, rounded to nearest and saturated.
// ----------------------------------------------------------------------------
// One pixel per clock sustained while out_tready stays high. The seven
// register stages are: sRGB curve lookup, matrix products, row sums and
// clamp, f table read, interpolation multiply, scaled differences, round and
// saturate. Each stage holds its word on a stall and takes a new one
// whenever it is empty, so input words are accepted while a result waits as
// long as any stage is free. No state carries between pixels.
module srgb_to_cielab_unit #(
  parameter int FRAC_BITS = s2l_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // lightness[14:0], green_red[30:15],
                                       // blue_yellow[46:31], zero[47]
);

  logic                            m_valid, m_ready;
  s2l_pkg::f_idx_t [2:0]           m_idx;
  logic                            f_valid, f_ready;
  logic [2:0][s2l_pkg::F_W-1:0]    f_val;
  logic        [14:0]              lightness;
  logic signed [15:0]              green_red, blue_yellow;

  s2l_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_red    (in_tdata[7:0]),
    .in_green  (in_tdata[15:8]),
    .in_blue   (in_tdata[23:16]),
    .out_valid (m_valid),
    .out_ready (m_ready),
    .out_idx   (m_idx)
  );

  s2l_lab_f u_lab_f (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid),
    .in_ready  (m_ready),
    .in_idx    (m_idx),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_f     (f_val)
  );

  s2l_lab_out #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lab_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (f_valid),
    .in_ready        (f_ready),
    .in_f            (f_val),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_lightness   (lightness),
    .out_green_red   (green_red),
    .out_blue_yellow (blue_yellow)
  );

  assign out_tdata = {1'b0, blue_yellow, green_red, lightness};

endmodule
`default_nettype wire

[sim/srgb_to_cielab_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srgb_to_cielab_checker: scoreboard for the sRGB to L*a*b* unit
// Watches both stream channels, computes the expected L*, a*, b* of each
// accepted pixel with its own fixed-point tables and compares each result
// word, in order, field by field.
// ----------------------------------------------------------------------------
module srgb_to_cielab_checker #(
  parameter int FRAC_BITS = s2l_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [47:0] out_tdata,
  output int               err_count,
  output int               pending
);

  localparam int RND_SHIFT = 20 - FRAC_BITS;
  localparam longint unsigned RATIO_TOP = (64'd1 << 20) + 64'd1023;
  localparam longint L_TOP = ((64'sd100 <<< FRAC_BITS) > 64'sd32767) ?
                             64'sd32767 : (64'sd100 <<< FRAC_BITS);

  typedef struct packed {
    logic [14:0]        lightness;
    logic signed [15:0] green_red;
    logic signed [15:0] blue_yellow;
  } lab_t;

  longint unsigned lin_lut [256];
  longint unsigned f_lut   [1026];
  longint unsigned xyz_coef [3][3];

  lab_t   lab_q [$];
  lab_t   want;
  longint word_no;

  // sRGB curve, Lab f curve and the white-normalized matrix, integer only
  initial begin
    longint unsigned num [3][3];
    longint unsigned scale [3];
    longint unsigned wdiv [3];
    longint unsigned t, u, lo, hi, mid, p, n;
    num   = '{'{4124, 3576, 1805}, '{2126, 7152, 722}, '{193, 1192, 9505}};
    scale = '{10, 1, 10};
    wdiv  = '{95047, 10000, 108883};
    for (int v = 0; v < 256; v++) begin
      if (v <= 10) begin
        lin_lut[v] = (longint'(v) * 6553600 + 329460 / 2) / 329460;
      end else begin
        t  = ((longint'(v) * 1000 + 14025) << 30) / 269025;
        u  = (t * t) >> 30;
        lo = 0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          p = (mid * mid) >> 30;
          p = (p * mid) >> 30;
          p = (p * mid) >> 30;
          p = (p * mid) >> 30;
          if (p <= u) lo = mid;
          else hi = mid - 1;
        end
        lin_lut[v] = (((u * lo) >> 30) + 64'd8192) >> 14;
      end
    end
    for (int k = 0; k < 1026; k++) begin
      if (k <= 9) begin
        f_lut[k] = (64'd24389 * longint'(k) * 1024 + (64'd432 << 20) + 3132 / 2) / 3132;
      end else begin
        n  = longint'(k) << 50;
        lo = 0;
        hi = (64'd1 << 21) - 1;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          if (mid * mid * mid <= n) lo = mid;
          else hi = mid - 1;
        end
        f_lut[k] = lo;
      end
    end
    for (int row = 0; row < 3; row++)
      for (int col = 0; col < 3; col++)
        xyz_coef[row][col] = ((num[row][col] * scale[row] << 20) + wdiv[row] / 2) / wdiv[row];
  end

  function automatic longint lab_curve(input longint unsigned ratio);
    longint unsigned k, q, lo, hi;
    if (ratio > RATIO_TOP) ratio = RATIO_TOP;
    k  = ratio >> 10;
    q  = ratio & 64'd1023;
    lo = f_lut[k];
    hi = f_lut[k + 1];
    return longint'(lo + (((hi - lo) * q + 64'd512) >> 10));
  endfunction

  // Q20 to output scale, nearest, ties up
  function automatic longint round_q20(input longint v);
    return (v + (64'sd1 <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
  endfunction

  function automatic lab_t predict_lab(input logic [23:0] pix);
    longint unsigned lin [3];
    longint unsigned sum;
    longint          f [3];
    longint          l, a, b;
    lab_t            res;
    lin[0] = lin_lut[pix[7:0]];
    lin[1] = lin_lut[pix[15:8]];
    lin[2] = lin_lut[pix[23:16]];
    for (int row = 0; row < 3; row++) begin
      sum = lin[0] * xyz_coef[row][0] + lin[1] * xyz_coef[row][1]
          + lin[2] * xyz_coef[row][2];
      f[row] = lab_curve((sum + 64'd32768) >> 16);
    end
    l = round_q20(116 * f[1] - (64'sd16 <<< 20));
    a = round_q20(500 * (f[0] - f[1]));
    b = round_q20(200 * (f[1] - f[2]));
    l = (l < 0) ? 0 : ((l > L_TOP) ? L_TOP : l);
    a = (a < -32768) ? -32768 : ((a > 32767) ? 32767 : a);
    b = (b < -32768) ? -32768 : ((b > 32767) ? 32767 : b);
    res.lightness   = l[14:0];
    res.green_red   = a[15:0];
    res.blue_yellow = b[15:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp_val);
    $display("checker: word %0d %s: got %0d, expected %0d", word_no, what, got, exp_val);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (lab_q.size() == 0) begin
          report_mismatch("result word with nothing pending", longint'(out_tdata), 0);
        end else begin
          want = lab_q.pop_front();
          if (out_tdata[14:0] != want.lightness)
            report_mismatch("lightness", longint'(out_tdata[14:0]),
                            longint'(want.lightness));
          if (out_tdata[30:15] != want.green_red)
            report_mismatch("green_red", longint'($signed(out_tdata[30:15])),
                            longint'(want.green_red));
          if (out_tdata[46:31] != want.blue_yellow)
            report_mismatch("blue_yellow", longint'($signed(out_tdata[46:31])),
                            longint'(want.blue_yellow));
          if (out_tdata[47] != 1'b0)
            report_mismatch("pad bit", longint'(out_tdata[47]), 0);
        end
        word_no++;
      end
      if (in_tvalid && in_tready) lab_q.push_back(predict_lab(in_tdata));
      pending = lab_q.size();
    end
  end

endmodule
`default_nettype wire

[sim/tb_srgb_to_cielab_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_srgb_to_cielab_unit: testbench for the sRGB to L*a*b* unit
// Drives directed corner pixels, then random pixels with random gaps on the
// input and random stalls on the output, including a long output hold-off
// that backs up the pipeline. A checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_srgb_to_cielab_unit;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // red[7:0], green[15:8], blue[23:16]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // lightness[14:0], green_red[30:15], blue_yellow[46:31]

  int errors;
  int pending;
  int idle_cycles;
  bit tx_gaps;
  bit rx_stalls;
  bit hold_req;

  srgb_to_cielab_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  srgb_to_cielab_checker lab_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .err_count  (errors),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // mostly short, a few long
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [7:0] corner_val();
    case ($urandom_range(0, 8))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd10;
      3: return 8'd11;
      4: return 8'd12;
      5: return 8'd128;
      6: return 8'd254;
      7: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    in_tdata  <= {b, g, r};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic run_random(input int count);
    logic [7:0] r, g, b;
    int         pick, gap;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        {r, g, b} = 24'($urandom);
      end else if (pick < 85) begin
        r = corner_val();
        g = corner_val();
        b = corner_val();
      end else begin
        r = 8'($urandom);
        g = r;
        b = r;
      end
      send_pixel(r, g, b);
      if (tx_gaps && $urandom_range(0, 99) < 35) begin
        gap = gap_len();
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // output side: random stalls plus one long hold-off on request
  initial begin
    int  stall_left;
    int  hold_left;
    bit  held;
    stall_left = 0;
    hold_left  = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (rx_stalls && $urandom_range(0, 99) < 30) begin
        stall_left = gap_len() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_srgb_to_cielab_unit: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 24'd0;
    tx_gaps     = 1'b0;
    rx_stalls   = 1'b0;
    hold_req    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // black gives L* of zero; white drives X and Z ratios past one
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    // linear segment of the sRGB curve and its edge
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd10,  8'd10,  8'd10);
    send_pixel(8'd11,  8'd11,  8'd11);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd10,  8'd11,  8'd12);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd254, 8'd254, 8'd254);
    send_pixel(8'd255, 8'd255, 8'd254);
    send_pixel(8'hAA,  8'h55,  8'hAA);
    send_pixel(8'h55,  8'hAA,  8'h55);
    send_pixel(8'h80,  8'h7F,  8'h01);
    send_pixel(8'd255, 8'd0,   8'd128);
    send_pixel(8'd0,   8'd128, 8'd255);

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);

    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    run_random(400);

    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    run_random(300);

    // long output hold-off while words keep coming
    hold_req = 1'b1;
    run_random(400);

    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    run_random(600);

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("tb_srgb_to_cielab_unit: done, clean");
    else
      $display("tb_srgb_to_cielab_unit: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
